>>> rtl/button_press_classifier_top_defines.svh
// Assertion macros used by the classifier top level
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpc: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpc: next-cycle check failed");

`endif

>>> rtl/bpc_pkg.sv
package bpc_pkg;

   // Event codes
   typedef logic [1:0] event_type;
   localparam event_type EV_NONE   = 2'd0;
   localparam event_type EV_SINGLE = 2'd1;
   localparam event_type EV_DOUBLE = 2'd2;
   localparam event_type EV_HOLD   = 2'd3;

   // Register port geometry
   localparam int CSR_IDX_BITS  = 8;
   localparam int CSR_DATA_BITS = 16;
   localparam int NOW_BITS      = 32;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   // Register indexes
   localparam csr_idx_type IDX_DEBOUNCE      = 8'd0;
   localparam csr_idx_type IDX_DOUBLE_WINDOW = 8'd1;
   localparam csr_idx_type IDX_HOLD_DELAY    = 8'd2;
   localparam csr_idx_type IDX_IDLE_LEVEL    = 8'd3;

   // Register reset values
   localparam logic [15:0] DEBOUNCE_RESET      = 16'd20;
   localparam logic [15:0] DOUBLE_WINDOW_RESET = 16'd250;
   localparam logic [15:0] HOLD_DELAY_RESET    = 16'd750;
   localparam logic        IDLE_LEVEL_RESET    = 1'b0;

   // Live configuration handed to the classifier
   typedef struct packed {
      logic [15:0] debounce_ms;
      logic [15:0] double_window_ms;
      logic [15:0] hold_delay_ms;
      logic        idle_level;
   } cfg_type;

endpackage

>>> rtl/bpc_ifs.sv
// Sample channel: one pin sample with its timestamp per beat
interface bpc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           pin_level;
   logic [bpc_pkg::NOW_BITS-1:0]   now_ms;

   modport source (output valid, pin_level, now_ms, input ready);
   modport sink   (input valid, pin_level, now_ms, output ready);
endinterface

// Result channel: one event code per beat
interface bpc_rsp_if;
   logic                 valid;
   logic                 ready;
   bpc_pkg::event_type   event_res;

   modport source (output valid, event_res, input ready);
   modport sink   (input valid, event_res, output ready);
endinterface

// Register write channel
interface bpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bpc_pkg::CSR_IDX_BITS-1:0]    wr_index;
   logic [bpc_pkg::CSR_DATA_BITS-1:0]   wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

>>> rtl/bpc_csr.sv
module bpc_csr (
   input  logic             clock,
   input  logic             reset,
   bpc_csr_if.sink          csr_ch,
   output bpc_pkg::cfg_type cfg
);
   import bpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ch.ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.wr_index)
            IDX_DEBOUNCE:      cfg_in.debounce_ms      = csr_ch.wr_data;
            IDX_DOUBLE_WINDOW: cfg_in.double_window_ms = csr_ch.wr_data;
            IDX_HOLD_DELAY:    cfg_in.hold_delay_ms    = csr_ch.wr_data;
            IDX_IDLE_LEVEL:    cfg_in.idle_level       = csr_ch.wr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= DEBOUNCE_RESET;
         cfg_ff.double_window_ms <= DOUBLE_WINDOW_RESET;
         cfg_ff.hold_delay_ms    <= HOLD_DELAY_RESET;
         cfg_ff.idle_level       <= IDLE_LEVEL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/bpc_core.sv
module bpc_core #(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_go,
   input  logic                   pin_level,
   input  logic [TIME_BITS-1:0]   now_ms,
   input  bpc_pkg::cfg_type       cfg,
   output bpc_pkg::event_type     event_res
);
   import bpc_pkg::*;

   logic                 prev_level_ff, prev_level_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic [TIME_BITS-1:0] release_time_ff, release_time_in;
   logic                 double_pending_ff, double_pending_in;
   logic                 double_on_rel_ff, double_on_rel_in;
   logic                 single_allowed_ff, single_allowed_in;
   logic                 ignore_release_ff, ignore_release_in;
   logic                 hold_seen_ff, hold_seen_in;

   logic                 down;
   logic                 was_idle;
   logic [TIME_BITS-1:0] since_up;
   logic [TIME_BITS-1:0] since_down;
   logic [TIME_BITS-1:0] since_rel_new;
   logic [TIME_BITS-1:0] since_press_new;
   logic [TIME_BITS-1:0] debounce_t;
   logic [TIME_BITS-1:0] window_t;
   logic [TIME_BITS-1:0] hold_t;
   event_type            ev;

   assign debounce_t = TIME_BITS'(cfg.debounce_ms);
   assign window_t   = TIME_BITS'(cfg.double_window_ms);
   assign hold_t     = TIME_BITS'(cfg.hold_delay_ms);

   // Edge qualification, window expiry and hold detection for one sample
   always_comb begin
      down       = pin_level != cfg.idle_level;
      was_idle   = prev_level_ff == cfg.idle_level;
      since_up   = now_ms - release_time_ff;
      since_down = now_ms - press_time_ff;

      press_time_in     = press_time_ff;
      release_time_in   = release_time_ff;
      double_pending_in = double_pending_ff;
      double_on_rel_in  = double_on_rel_ff;
      single_allowed_in = single_allowed_ff;
      ignore_release_in = ignore_release_ff;
      hold_seen_in      = hold_seen_ff;
      ev                = EV_NONE;

      if (down && was_idle && (since_up > debounce_t)) begin
         // accepted press
         press_time_in     = now_ms;
         ignore_release_in = 1'b0;
         single_allowed_in = 1'b1;
         hold_seen_in      = 1'b0;
         if ((since_up < window_t) && !double_on_rel_ff && double_pending_ff) begin
            double_on_rel_in = 1'b1;
         end else begin
            double_on_rel_in  = 1'b0;
            double_pending_in = 1'b0;
         end
      end else if (!down && !was_idle && (since_down > debounce_t)) begin
         // accepted release, unless a hold swallowed it
         if (!ignore_release_ff) begin
            release_time_in = now_ms;
            if (!double_on_rel_ff) begin
               double_pending_in = 1'b1;
            end else begin
               ev                = EV_DOUBLE;
               double_on_rel_in  = 1'b0;
               double_pending_in = 1'b0;
               single_allowed_in = 1'b0;
            end
         end
      end

      // window expired after a lone press
      since_rel_new = now_ms - release_time_in;
      if (!down && (since_rel_new >= window_t) && double_pending_in && !double_on_rel_in
          && single_allowed_in && (ev != EV_DOUBLE)) begin
         ev                = EV_SINGLE;
         double_pending_in = 1'b0;
      end

      // hold, repeating every hold delay
      since_press_new = now_ms - press_time_in;
      if (down && (since_press_new >= hold_t)) begin
         if (!hold_seen_in) begin
            ignore_release_in = 1'b1;
            double_on_rel_in  = 1'b0;
            double_pending_in = 1'b0;
            hold_seen_in      = 1'b1;
         end
         press_time_in = now_ms;
         ev            = EV_HOLD;
      end

      prev_level_in = pin_level;
   end

   // State update, one sample per beat
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff     <= 1'b1;
         press_time_ff     <= '1;
         release_time_ff   <= '1;
         double_pending_ff <= 1'b0;
         double_on_rel_ff  <= 1'b0;
         single_allowed_ff <= 1'b0;
         ignore_release_ff <= 1'b0;
         hold_seen_ff      <= 1'b0;
      end else if (item_go) begin
         prev_level_ff     <= prev_level_in;
         press_time_ff     <= press_time_in;
         release_time_ff   <= release_time_in;
         double_pending_ff <= double_pending_in;
         double_on_rel_ff  <= double_on_rel_in;
         single_allowed_ff <= single_allowed_in;
         ignore_release_ff <= ignore_release_in;
         hold_seen_ff      <= hold_seen_in;
      end
   end

   assign event_res = ev;

endmodule

>>> rtl/button_press_classifier_top.sv
// Button press classifier: single press, double press and hold events.
// A sample beat is captured in the input register; its event is written to
// the result register once that register is empty or being drained.
// Throughput: one sample per cycle while events are taken; the input and
// result registers let a new sample in while a finished event waits.
// Reset (synchronous, active high) restores register defaults, clears all
// flags and sets both edge timestamps to all ones.
module button_press_classifier_top #(
   parameter int TIME_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   bpc_req_if.sink    req_ch,
   bpc_rsp_if.source  rsp_ch,
   bpc_csr_if.sink    csr_ch
);
   import bpc_pkg::*;

`include "button_press_classifier_top_defines.svh"

   cfg_type              cfg;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_level_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   event_type            event_ff;
   event_type            core_ev;
   logic                 advance;
   logic                 req_fire;
   logic                 item_go;
   logic                 in_down;

   bpc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Stage moves when the result register is empty or being drained
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign item_go      = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_level_ff <= req_ch.pin_level;
         in_now_ff   <= TIME_BITS'(req_ch.now_ms);
      end
   end

   bpc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .item_go   (item_go),
      .pin_level (in_level_ff),
      .now_ms    (in_now_ff),
      .cfg       (cfg),
      .event_res (core_ev)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (item_go) begin
         event_ff <= core_ev;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.event_res = event_ff;

   // Checks
   assign in_down = in_level_ff != cfg.idle_level;

   `BPC_ASSERT_NEXT(a_item_lands, clock, reset, item_go, rsp_valid_ff)
   `BPC_ASSERT_NOW(a_stall_only_full, clock, reset, !req_ch.ready, in_valid_ff && rsp_valid_ff)
   `BPC_ASSERT_NOW(a_hold_when_down, clock, reset, item_go && (core_ev == EV_HOLD), in_down)
   `BPC_ASSERT_NOW(a_double_when_up, clock, reset, item_go && (core_ev == EV_DOUBLE), !in_down)

endmodule

>>> tb/sv/button_press_classifier_top_tb.sv
module button_press_classifier_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bpc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int QUIET_SLACK     = 4;
   localparam int DRAIN_LIMIT     = 1000;
   localparam int PHASE_ITEMS     = 280;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int MAX_REPORTS     = 40;

   // Indexes outside the register map, which the block must ignore
   localparam csr_idx_type IDX_FIRST_UNUSED = IDX_IDLE_LEVEL + 8'd1;
   localparam csr_idx_type IDX_LAST_UNUSED  = '1;

   logic clock;
   logic reset;

   bpc_req_if req_bus ();
   bpc_rsp_if rsp_bus ();
   bpc_csr_if csr_bus ();

   button_press_classifier_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Classifier settings as last written
   logic [15:0] deb_ms;
   logic [15:0] win_ms;
   logic [15:0] hold_ms;
   logic        idle_pin;

   // Classifier state
   logic                last_pin;
   logic [NOW_BITS-1:0] t_press;
   logic [NOW_BITS-1:0] t_release;
   logic                dbl_armed;
   logic                dbl_second;
   logic                single_ok;
   logic                skip_release;
   logic                held;

   event_type           event_codes_due[$];
   logic [NOW_BITS-1:0] sample_clock_ms;

   int  error_count = 0;
   int  n_sent = 0;
   int  n_settings = 0;
   int  n_none = 0;
   int  n_single = 0;
   int  n_double = 0;
   int  n_hold = 0;
   int  quiet_cycles = 0;
   int  hold_off_request = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_stalls = 1'b1;

   // Clock, 2 ns period
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      // keep the log short when one fault cascades
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------
   // Event prediction
   // ---------------------------------------------------------------
   function automatic void clear_classifier();
      deb_ms       = DEBOUNCE_RESET;
      win_ms       = DOUBLE_WINDOW_RESET;
      hold_ms      = HOLD_DELAY_RESET;
      idle_pin     = IDLE_LEVEL_RESET;
      last_pin     = 1'b1;
      t_press      = '1;
      t_release    = '1;
      dbl_armed    = 1'b0;
      dbl_second   = 1'b0;
      single_ok    = 1'b0;
      skip_release = 1'b0;
      held         = 1'b0;
   endfunction

   function automatic void store_setting(input csr_idx_type idx,
                                         input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         IDX_DEBOUNCE:      deb_ms = data;
         IDX_DOUBLE_WINDOW: win_ms = data;
         IDX_HOLD_DELAY:    hold_ms = data;
         IDX_IDLE_LEVEL:    idle_pin = data[0];
         default: ;
      endcase
   endfunction

   // All time differences wrap at the timestamp width and compare unsigned
   function automatic event_type classify_sample(input logic pin,
                                                 input logic [NOW_BITS-1:0] now);
      logic                pressed;
      logic                was_up;
      logic [NOW_BITS-1:0] since_up;
      logic [NOW_BITS-1:0] since_down;
      event_type           ev;
      pressed  = (pin != idle_pin);
      was_up   = (last_pin == idle_pin);
      since_up = now - t_release;
      ev       = EV_NONE;

      // qualified edges
      since_down = now - t_press;
      if (pressed && was_up && since_up > {16'd0, deb_ms}) begin
         t_press      = now;
         skip_release = 1'b0;
         single_ok    = 1'b1;
         held         = 1'b0;
         if (since_up < {16'd0, win_ms} && !dbl_second && dbl_armed) begin
            dbl_second = 1'b1;
         end else begin
            dbl_second = 1'b0;
            dbl_armed  = 1'b0;
         end
      end else if (!pressed && !was_up && since_down > {16'd0, deb_ms}) begin
         if (!skip_release) begin
            t_release = now;
            if (!dbl_second) begin
               dbl_armed = 1'b1;
            end else begin
               ev         = EV_DOUBLE;
               dbl_second = 1'b0;
               dbl_armed  = 1'b0;
               single_ok  = 1'b0;
            end
         end
      end

      // single press once the window has run out
      since_up = now - t_release;
      if (!pressed && since_up >= {16'd0, win_ms} && dbl_armed && !dbl_second &&
          single_ok && ev != EV_DOUBLE) begin
         ev        = EV_SINGLE;
         dbl_armed = 1'b0;
      end

      // hold, repeating every hold delay
      since_down = now - t_press;
      if (pressed && since_down >= {16'd0, hold_ms}) begin
         if (!held) begin
            skip_release = 1'b1;
            dbl_second   = 1'b0;
            dbl_armed    = 1'b0;
            held         = 1'b1;
         end
         t_press = now;
         ev      = EV_HOLD;
      end

      last_pin = pin;
      return ev;
   endfunction

   // ---------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------
   task automatic send_sample(input logic pin, input logic [NOW_BITS-1:0] stamp);
      if (sender_gaps && $urandom_range(0, 9) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pin_level <= pin;
      req_bus.now_ms    <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      event_codes_due.push_back(classify_sample(pin, stamp));
      n_sent++;
   endtask

   // Leaves valid high so that back-to-back writes need no re-raise
   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_bus.valid    <= 1'b1;
      csr_bus.wr_index <= idx;
      csr_bus.wr_data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      store_setting(idx, data);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (event_codes_due.size() != 0) @(posedge clock);
      repeat (QUIET_SLACK) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] deb, input logic [15:0] win,
                                 input logic [15:0] hold, input logic idle);
      wait_quiet();
      write_reg(IDX_DEBOUNCE, deb);
      write_reg(IDX_DOUBLE_WINDOW, win);
      write_reg(IDX_HOLD_DELAY, hold);
      write_reg(IDX_IDLE_LEVEL, {15'd0, idle});
      csr_bus.valid <= 1'b0;
      n_settings++;
   endtask

   // ---------------------------------------------------------------
   // Gesture building
   // ---------------------------------------------------------------
   task automatic step_to(input bit pressed, input int dt);
      sample_clock_ms = sample_clock_ms + dt;
      send_sample(pressed ? ~idle_pin : idle_pin, sample_clock_ms);
   endtask

   function automatic int span(input int lo, input int hi);
      return (hi <= lo) ? lo : int'($urandom_range(hi, lo));
   endfunction

   // one below, on or one above a threshold
   function automatic int near(input int th);
      int v;
      v = th + int'($urandom_range(0, 2)) - 1;
      return (v < 0) ? 0 : v;
   endfunction

   function automatic int settle_len();
      if ($urandom_range(0, 4) == 0) return near(int'(deb_ms));
      return span(int'(deb_ms) + 1, int'(deb_ms) + 40);
   endfunction

   function automatic int tap_len();
      if ($urandom_range(0, 3) == 0)
         return near($urandom_range(0, 1) ? int'(deb_ms) : int'(hold_ms));
      return span(int'(deb_ms) + 1, int'(hold_ms) - 1);
   endfunction

   function automatic int double_gap();
      if ($urandom_range(0, 3) == 0)
         return near($urandom_range(0, 1) ? int'(deb_ms) : int'(win_ms));
      return span(int'(deb_ms) + 1, int'(win_ms) - 1);
   endfunction

   function automatic int after_window();
      if ($urandom_range(0, 3) == 0) return near(int'(win_ms));
      return span(int'(win_ms), int'(win_ms) + 200);
   endfunction

   // press after gap, stay down for len with a few samples, then release
   task automatic tap(input int gap, input int len);
      int n;
      int dt;
      n  = $urandom_range(0, 2);
      dt = len / (n + 1);
      step_to(1'b1, gap);
      repeat (n) step_to(1'b1, dt);
      step_to(1'b0, len - n * dt);
   endtask

   task automatic rest(input int len);
      int n;
      int dt;
      n  = $urandom_range(1, 3);
      dt = len / n;
      repeat (n - 1) step_to(1'b0, dt);
      step_to(1'b0, len - (n - 1) * dt);
   endtask

   task automatic random_gesture();
      int  kind;
      bit  lvl;
      logic [NOW_BITS-1:0] jump;
      kind = $urandom_range(0, 19);
      if (kind < 6) begin
         // single press
         tap(settle_len(), tap_len());
         rest(after_window());
      end else if (kind < 12) begin
         // double press, second press near the window edges at times
         tap(settle_len(), tap_len());
         tap(double_gap(), tap_len());
         rest(after_window());
      end else if (kind < 15) begin
         // long press through one or more hold periods
         step_to(1'b1, settle_len());
         repeat ($urandom_range(1, 6))
            step_to(1'b1, $urandom_range(0, 2) == 0 ? near(int'(hold_ms)) :
                    span(int'(hold_ms) / 2, int'(hold_ms) + int'(hold_ms) / 2));
         step_to(1'b0, span(0, 2 * int'(deb_ms) + 2));
         rest(after_window());
      end else if (kind < 17) begin
         // contact bounce inside the debounce time
         lvl = 1'b1;
         repeat ($urandom_range(2, 6)) begin
            step_to(lvl, span(0, int'(deb_ms)));
            lvl = ~lvl;
         end
         rest(after_window());
      end else begin
         // noise: random pin and time jumps, some across the whole timer range
         repeat ($urandom_range(1, 6)) begin
            jump = ($urandom_range(0, 3) == 0) ? $urandom :
                   span(0, 2 * int'(deb_ms) + int'(hold_ms));
            sample_clock_ms = sample_clock_ms + jump;
            send_sample(1'($urandom_range(0, 1)), sample_clock_ms);
         end
      end
   endtask

   task automatic run_gestures(input int count);
      int target;
      target = n_sent + count;
      while (n_sent < target) random_gesture();
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Reset settings and state: first sample at time zero, then one of each event
   task automatic test_reset_state();
      sample_clock_ms = '0;
      step_to(1'b0, 0);
      tap(30, 100);
      rest(270);
      tap(100, 60);
      tap(40, 60);
      step_to(1'b1, 300);
      step_to(1'b1, 750);
      step_to(1'b1, 750);
      step_to(1'b0, 100);
   endtask

   // Press before the timer wrap, release on an all-ones stamp, last sample past the wrap
   task automatic test_timer_wrap();
      sample_clock_ms = 32'hFFFF_FE00;
      step_to(1'b0, 0);
      step_to(1'b1, 300);
      step_to(1'b0, 211);
      step_to(1'b0, 300);
   endtask

   // Zero debounce, zero window, zero hold delay, pull-up pin
   task automatic test_zero_settings();
      apply_settings('0, '0, '0, 1'b1);
      step_to(1'b0, 1);
      step_to(1'b1, 1);
      step_to(1'b1, 0);
      step_to(1'b0, 0);
      step_to(1'b0, 5);
      tap(2, 3);
   endtask

   // Writes to indexes past the register map change nothing
   task automatic test_unknown_index();
      wait_quiet();
      write_reg(IDX_FIRST_UNUSED, '1);
      write_reg(IDX_LAST_UNUSED, 16'h1234);
      csr_bus.valid <= 1'b0;
      step_to(1'b1, 10);
      step_to(1'b0, 10);
   endtask

   // Result side held off while samples keep coming, then a full drain and more gestures
   task automatic test_backpressure();
      apply_settings(16'd10, 16'd150, 16'd400, 1'b0);
      hold_off_request = HOLD_OFF_CYCLES;
      run_gestures(40);
      wait_quiet();
      run_gestures(20);
   endtask

   task automatic test_random_settings();
      logic [15:0] deb;
      logic [15:0] win;
      logic [15:0] hold;
      apply_settings(DEBOUNCE_RESET, DOUBLE_WINDOW_RESET, HOLD_DELAY_RESET, 1'b0);
      run_gestures(PHASE_ITEMS);
      apply_settings('0, '0, 16'd1, 1'b1);
      run_gestures(PHASE_ITEMS);
      apply_settings('1, '1, '1, 1'b0);
      run_gestures(PHASE_ITEMS);
      repeat (2) begin
         deb  = 16'($urandom_range(0, 60));
         win  = 16'($urandom_range(0, 400));
         hold = 16'($urandom_range(1, 1000));
         apply_settings(deb, win, hold, 1'($urandom_range(0, 1)));
         run_gestures(PHASE_ITEMS);
      end
   endtask

   // Last stretch with no idling on either side
   task automatic test_steady_stream();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      apply_settings(16'd5, 16'd120, 16'd300, 1'b1);
      run_gestures(PHASE_ITEMS);
   endtask

   // ---------------------------------------------------------------
   // Result side: ready pattern and checking
   // ---------------------------------------------------------------
   initial begin
      int stall;
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_request != 0) begin
            stall = hold_off_request;
            hold_off_request = 0;
         end else if (receiver_stalls && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(1, 8);
         end else begin
            stall = 0;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (event_codes_due.size() == 0) begin
            report_mismatch($sformatf("event beat %0d with nothing outstanding",
                                      rsp_bus.event_res));
         end else begin
            want = event_codes_due.pop_front();
            if (rsp_bus.event_res !== want)
               report_mismatch($sformatf("event_res got %0d, want %0d",
                                         rsp_bus.event_res, want));
            case (want)
               EV_SINGLE: n_single++;
               EV_DOUBLE: n_double++;
               EV_HOLD:   n_hold++;
               default:   n_none++;
            endcase
         end
      end
   end

   // Watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      int waited;
      clear_classifier();
      sample_clock_ms   = '0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.pin_level <= 1'b0;
      req_bus.now_ms    <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.wr_index  <= '0;
      csr_bus.wr_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_timer_wrap();
      test_zero_settings();
      test_unknown_index();
      test_backpressure();
      test_random_settings();
      test_steady_stream();

      // drain
      req_bus.valid <= 1'b0;
      waited = 0;
      while (event_codes_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (QUIET_SLACK) @(posedge clock);
      if (event_codes_due.size() != 0)
         report_mismatch($sformatf("%0d events never arrived", event_codes_due.size()));

      $display("Run covered %0d samples under %0d register settings, incl. timer wrap,",
               n_sent, n_settings);
      $display("bounce, noise and result hold-off; events: %0d none, %0d single,",
               n_none, n_single);
      $display("%0d double, %0d hold", n_double, n_hold);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
